// ===== rtl/xsge_pkg.sv =====
// Shared constants, coefficient and curve tables for the XYZ to sRGB encoder.
package xsge_pkg;

  localparam int IN_BITS_DEF  = 16;
  localparam int OUT_BITS_DEF = 12;

  // Stage counts: two matrix stages, then the per-channel encoder.
  localparam int MAT_STG = 2;
  localparam int ENC_STG = 7;
  localparam int NSTG    = MAT_STG + ENC_STG;

  // Signed Q.16 sRGB primaries matrix.
  localparam int COEF_W = 19;
  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t MAT [3][3] = '{
    '{ 19'sd212402, -19'sd100755, -19'sd32676 },
    '{-19'sd63517,   19'sd122946,  19'sd2726  },
    '{ 19'sd3644,   -19'sd13369,   19'sd69272 }
  };

  // Curve constants.
  localparam int LIN_W  = 24;   // linear value, Q.24
  localparam int V_W    = 21;   // encoded value, Q.20 up to 1.0
  localparam int MANT_W = 21;
  localparam int SEMI_W = 21;   // entry 0 is exactly 1.0
  localparam int FR_W   = 19;
  localparam int DIF_W  = 15;

  localparam logic [15:0]       KNEE   = 16'd51003;
  localparam logic [19:0]       SLOPE  = 20'd846725;
  localparam logic [V_W-1:0]    GAIN   = 21'd1106248;
  localparam logic [V_W-1:0]    OFFSET = 21'd57672;
  localparam logic [V_W-1:0]    ONE20  = 21'h100000;
  localparam logic [V_W-1:0]    HALF20 = 21'h080000;

  // (1 + k/16)^(5/12), Q.20
  localparam logic [MANT_W-1:0] MANT [17] = '{
    21'd1048576, 21'd1075401, 21'd1101320, 21'd1126412, 21'd1150745, 21'd1174377,
    21'd1197364, 21'd1219747, 21'd1241569, 21'd1262869, 21'd1283676, 21'd1304022,
    21'd1323932, 21'd1343432, 21'd1362544, 21'd1381287, 21'd1399681
  };

  // 2^(-r/12), Q.20
  localparam logic [SEMI_W-1:0] SEMI [12] = '{
    21'd1048576, 21'd989724, 21'd934175, 21'd881744, 21'd832255, 21'd785544,
    21'd741455,  21'd699840, 21'd660561, 21'd623487, 21'd588493, 21'd555464
  };

  typedef struct packed {
    logic [1:0] q;
    logic [3:0] r;
  } qr_t;

  // 5*e split into whole octaves (q) and semitone steps (r), e in 1..9.
  function automatic qr_t qr_of(input logic [3:0] e);
    qr_t res;
    unique case (e)
      4'd1:    res = '{q: 2'd0, r: 4'd5};
      4'd2:    res = '{q: 2'd0, r: 4'd10};
      4'd3:    res = '{q: 2'd1, r: 4'd3};
      4'd4:    res = '{q: 2'd1, r: 4'd8};
      4'd5:    res = '{q: 2'd2, r: 4'd1};
      4'd6:    res = '{q: 2'd2, r: 4'd6};
      4'd7:    res = '{q: 2'd2, r: 4'd11};
      4'd8:    res = '{q: 2'd3, r: 4'd4};
      4'd9:    res = '{q: 2'd3, r: 4'd9};
      default: res = '{q: 2'd0, r: 4'd0};
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/xsge_xyz_if.sv =====
// Valid/ready channel carrying one XYZ pixel word.
interface xsge_xyz_if #(
  parameter int IN_BITS = xsge_pkg::IN_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] x_value;
  logic [IN_BITS-1:0] y_value;
  logic [IN_BITS-1:0] z_value;

  modport source (output valid, output x_value, output y_value, output z_value,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input z_value,
                  output ready);
endinterface

// ===== rtl/xsge_rgb_if.sv =====
// Valid/ready channel carrying one encoded sRGB word.
interface xsge_rgb_if #(
  parameter int OUT_BITS = xsge_pkg::OUT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] red_code;
  logic [OUT_BITS-1:0] green_code;
  logic [OUT_BITS-1:0] blue_code;

  modport source (output valid, output red_code, output green_code, output blue_code,
                  input ready);
  modport sink   (input valid, input red_code, input green_code, input blue_code,
                  output ready);
endinterface

// ===== rtl/xsge_encode.sv =====
// Seven-stage gamma encoder for one linear channel.
module xsge_encode #(
  parameter int IN_BITS  = xsge_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = xsge_pkg::OUT_BITS_DEF
) (
  input  logic                                clk,
  input  logic signed [IN_BITS+19:0]          acc,
  input  logic [xsge_pkg::ENC_STG-1:0]        ld,
  output logic [OUT_BITS-1:0]                 code
);
  import xsge_pkg::*;

  localparam int ACC_W     = IN_BITS + 20;
  localparam int LIN_SHIFT = IN_BITS - 10;
  localparam int U_W       = ACC_W - LIN_SHIFT;
  localparam int FRP_W     = DIF_W + FR_W;
  localparam int LINP_W    = 16 + 20;
  localparam int SP_W      = MANT_W + SEMI_W;
  localparam int GP_W      = V_W + V_W;
  localparam int CP_W      = V_W + OUT_BITS;
  localparam logic [CP_W-1:0] CODE_MAX = CP_W'((1 << OUT_BITS) - 1);

  typedef enum logic [1:0] {CLS_ZERO, CLS_FULL, CLS_LIN, CLS_CURVE} cls_t;

  // ---- stage A: classify, normalize
  logic signed [ACC_W-1:0] acc_sh;
  logic [U_W-1:0]          u;
  logic [LIN_W-1:0]        u24;
  logic                    pos;
  logic                    big;
  logic [3:0]              sh;
  cls_t                    cls_next;

  assign acc_sh = acc >>> LIN_SHIFT;
  assign u      = acc_sh[U_W-1:0];
  assign u24    = u[LIN_W-1:0];
  assign pos    = ~acc[ACC_W-1] & (|acc);
  assign big    = |u[U_W-1:LIN_W];

  // Curve inputs are at least the knee, so the top set bit is 15 or above.
  always_comb begin
    sh = 4'd8;
    for (int i = 0; i <= 8; i++) begin
      if (u24[15+i]) sh = 4'(8 - i);
    end
  end

  always_comb begin
    priority if (!pos)          cls_next = CLS_ZERO;
    else if (big)               cls_next = CLS_FULL;
    else if (u24 < 24'(KNEE))   cls_next = CLS_LIN;
    else                        cls_next = CLS_CURVE;
  end

  cls_t             cls_a;
  logic [LIN_W-1:0] m_a;
  logic [3:0]       e_a;
  logic [15:0]      ulin_a;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      cls_a  <= cls_next;
      m_a    <= u24 << sh;
      e_a    <= sh + 4'd1;
      ulin_a <= u24[15:0];
    end
  end

  // ---- stage B: table lookup, interpolation product, linear product
  logic [3:0]        idx;
  logic [FR_W-1:0]   fr;
  logic [MANT_W-1:0] mant_lo;
  logic [MANT_W-1:0] mant_hi;
  logic [MANT_W-1:0] dif_w;

  assign idx     = m_a[22:19];
  assign fr      = m_a[FR_W-1:0];
  assign mant_lo = MANT[{1'b0, idx}];
  assign mant_hi = MANT[{1'b0, idx} + 5'd1];
  assign dif_w   = mant_hi - mant_lo;

  cls_t              cls_b;
  logic [FRP_W-1:0]  frp_b;
  logic [MANT_W-1:0] base_b;
  qr_t               qr_b;
  logic [LINP_W-1:0] linp_b;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cls_b  <= cls_a;
      frp_b  <= dif_w[DIF_W-1:0] * fr;
      base_b <= mant_lo;
      qr_b   <= qr_of(e_a);
      linp_b <= ulin_a * SLOPE;
    end
  end

  // ---- stage C: interpolated mantissa power
  cls_t              cls_c;
  logic [MANT_W-1:0] g_c;
  qr_t               qr_c;
  logic [LINP_W-1:0] linp_c;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      cls_c  <= cls_b;
      g_c    <= base_b + MANT_W'(frp_b[FRP_W-1:FR_W]);
      qr_c   <= qr_b;
      linp_c <= linp_b;
    end
  end

  // ---- stage D: semitone scale
  cls_t              cls_d;
  logic [SP_W-1:0]   sp_d;
  logic [1:0]        q_d;
  logic [LINP_W-1:0] linp_d;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      cls_d  <= cls_c;
      sp_d   <= g_c * SEMI[qr_c.r];
      q_d    <= qr_c.q;
      linp_d <= linp_c;
    end
  end

  // ---- stage E: octave shift and 1.055 gain; round linear branch
  // The scaled mantissa never exceeds the top table entry, so 21 bits hold it.
  logic [V_W-1:0]    p;
  logic [LINP_W-1:0] linr;

  assign p    = sp_d[V_W+19:20] >> q_d;
  assign linr = linp_d + LINP_W'(HALF20);

  cls_t            cls_e;
  logic [GP_W-1:0] gp_e;
  logic [15:0]     linv_e;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      cls_e  <= cls_d;
      gp_e   <= p * GAIN;
      linv_e <= linr[LINP_W-1:20];
    end
  end

  // ---- stage F: offset, clip, branch select
  logic [GP_W-1:0] gr;
  logic [21:0]     t;
  logic [21:0]     tv;
  logic [V_W-1:0]  curve_v;
  logic [V_W-1:0]  v_next;

  assign gr = gp_e + GP_W'(HALF20);
  assign t  = gr[GP_W-1:20];

  always_comb begin
    tv = (t > 22'(OFFSET)) ? t - 22'(OFFSET) : 22'd0;
    curve_v = (tv > 22'(ONE20)) ? ONE20 : tv[V_W-1:0];
    unique case (cls_e)
      CLS_ZERO:  v_next = '0;
      CLS_FULL:  v_next = ONE20;
      CLS_LIN:   v_next = V_W'(linv_e);
      CLS_CURVE: v_next = curve_v;
      default:   v_next = '0;
    endcase
  end

  logic [V_W-1:0] v_f;

  always_ff @(posedge clk) begin
    if (ld[5]) v_f <= v_next;
  end

  // ---- stage G: scale to code range (output register)
  logic [CP_W-1:0]   cprod;
  logic [OUT_BITS:0] c;

  assign cprod = CP_W'(v_f) * CODE_MAX + CP_W'(HALF20);
  assign c     = cprod[CP_W-1:20];

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      code <= (c > CODE_MAX[OUT_BITS:0]) ? CODE_MAX[OUT_BITS-1:0] : c[OUT_BITS-1:0];
    end
  end

endmodule

// ===== rtl/xyz_to_srgb_gamma_encode.sv =====
// Top level: CIE XYZ to gamma-encoded sRGB pixel converter.
// Path: product and sum registers, then the encoder stages, from an accepted XYZ word to its RGB word.
// Throughput: one pixel word per cycle while rgb.ready holds; bubbles close up under stall.
// Reset (rst, synchronous): clears the stage valid bits only; data regs are not reset.
// Stall: each stage loads when it is empty or the stage after it moves, so the
// input stays ready while the output word waits, until the pipe is full.
module xyz_to_srgb_gamma_encode #(
  parameter int IN_BITS  = xsge_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = xsge_pkg::OUT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  xsge_xyz_if.sink   xyz,
  xsge_rgb_if.source rgb
);
  import xsge_pkg::*;

  localparam int ACC_W = IN_BITS + 20;

  // Stage map:
  //   0     three signed products per channel
  //   1     channel sums (exact, signed)
  //   2..8  gamma encoder, stage 8 is the output register
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] ld;

  // A stage may load when it is empty or its word moves on this cycle.
  always_comb begin
    ld[NSTG-1] = ~vld[NSTG-1] | rgb.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = ~vld[k] | ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= xyz.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign xyz.ready = ld[0];
  assign rgb.valid = vld[NSTG-1];

  // Inputs as signed, zero-extended operands.
  logic signed [IN_BITS:0] xin [3];

  assign xin[0] = $signed({1'b0, xyz.x_value});
  assign xin[1] = $signed({1'b0, xyz.y_value});
  assign xin[2] = $signed({1'b0, xyz.z_value});

  // Matrix products, one register per product.
  logic signed [ACC_W-1:0] prod [3][3];
  logic signed [ACC_W-1:0] acc  [3];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int j = 0; j < 3; j++) begin
          prod[ch][j] <= ACC_W'(MAT[ch][j]) * ACC_W'(xin[j]);
        end
      end
    end
  end

  // Row sums; the sum of coefficient magnitudes stays under 2^19, so no overflow.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= prod[ch][0] + prod[ch][1] + prod[ch][2];
      end
    end
  end

  // One encoder per channel, all stepping on the shared load enables.
  logic [OUT_BITS-1:0] code [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_enc
    xsge_encode #(
      .IN_BITS  (IN_BITS),
      .OUT_BITS (OUT_BITS)
    ) u_enc (
      .clk  (clk),
      .acc  (acc[ch]),
      .ld   (ld[NSTG-1:MAT_STG]),
      .code (code[ch])
    );
  end

  assign rgb.red_code   = code[0];
  assign rgb.green_code = code[1];
  assign rgb.blue_code  = code[2];

endmodule

// ===== tb/xyz_to_srgb_gamma_encode_test.sv =====
// Testbench for the XYZ to sRGB gamma encoder: a scoreboard checks each RGB word.
module xyz_to_srgb_gamma_encode_test;

  localparam int IN_W  = xsge_pkg::IN_BITS_DEF;
  localparam int OUT_W = xsge_pkg::OUT_BITS_DEF;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_word_t;

  // Holds predicted RGB words in order of acceptance and checks outgoing ones.
  class srgb_scoreboard;
    rgb_word_t   pending_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // (1 + k/16)^(5/12), Q.20
    function longint unsigned root_knot(int k);
      case (k)
        0:  return 1048576;  1:  return 1075401;  2:  return 1101320;
        3:  return 1126412;  4:  return 1150745;  5:  return 1174377;
        6:  return 1197364;  7:  return 1219747;  8:  return 1241569;
        9:  return 1262869;  10: return 1283676;  11: return 1304022;
        12: return 1323932;  13: return 1343432;  14: return 1362544;
        15: return 1381287;  default: return 1399681;
      endcase
    endfunction

    // 2^(-r/12), Q.20
    function longint unsigned semitone(int r);
      case (r)
        0:  return 1048576;  1:  return 989724;  2:  return 934175;
        3:  return 881744;   4:  return 832255;  5:  return 785544;
        6:  return 741455;   7:  return 699840;  8:  return 660561;
        9:  return 623487;   10: return 588493;  default: return 555464;
      endcase
    endfunction

    // Linear channel sum (input scale times Q.16 coefficient) to output code.
    function logic [OUT_W-1:0] encode_linear(longint acc);
      longint unsigned u, m, g, p, t, v, c, fr, lo, hi;
      longint unsigned code_max;
      int e, idx;
      code_max = (64'd1 << OUT_W) - 1;
      if (acc <= 0) return '0;
      u = unsigned'(acc) >> (IN_W - 10);
      if (u >= (64'd1 << 24)) begin
        v = 64'd1 << 20;
      end else if (u < 51003) begin
        v = (u * 846725 + (64'd1 << 19)) >> 20;
      end else begin
        // normalize into [2^23, 2^24), e counts the octaves below one
        m = u;
        e = 1;
        while (m < (64'd1 << 23)) begin
          m = m << 1;
          e++;
        end
        idx = int'((m >> 19) & 15);
        fr  = m & 64'h7FFFF;
        lo  = root_knot(idx);
        hi  = root_knot(idx + 1);
        g   = lo + (((hi - lo) * fr) >> 19);
        p   = ((g * semitone((5 * e) % 12)) >> 20) >> ((5 * e) / 12);
        t   = (p * 1106248 + (64'd1 << 19)) >> 20;
        v   = (t > 57672) ? t - 57672 : 0;
        if (v > (64'd1 << 20)) v = 64'd1 << 20;
      end
      c = (v * code_max + (64'd1 << 19)) >> 20;
      if (c > code_max) c = code_max;
      return c[OUT_W-1:0];
    endfunction

    function rgb_word_t predict_rgb(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                    logic [IN_W-1:0] z);
      rgb_word_t w;
      longint xs, ys, zs;
      xs = longint'(x);
      ys = longint'(y);
      zs = longint'(z);
      w.red   = encode_linear( 212402 * xs - 100755 * ys -  32676 * zs);
      w.green = encode_linear(- 63517 * xs + 122946 * ys +   2726 * zs);
      w.blue  = encode_linear(   3644 * xs -  13369 * ys +  69272 * zs);
      return w;
    endfunction

    function void note_pixel(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
      pending_q.push_back(predict_rgb(x, y, z));
    endfunction

    function void check_word(rgb_word_t got);
      rgb_word_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected word r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        return;
      end
      want = pending_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void flag_leftovers();
      if (pending_q.size() != 0) begin
        errors++;
        $display("ERROR: %0d predicted words never came out", pending_q.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  xsge_xyz_if #(.IN_BITS(IN_W))   xyz_ch ();
  xsge_rgb_if #(.OUT_BITS(OUT_W)) rgb_ch ();

  xyz_to_srgb_gamma_encode #(.IN_BITS(IN_W), .OUT_BITS(OUT_W)) u_dut (
    .clk (clk),
    .rst (rst),
    .xyz (xyz_ch),
    .rgb (rgb_ch)
  );

  srgb_scoreboard sb = new();

  // Idle control: quiet flags switch off random gaps; hold_len asks the
  // receiver for one long stall.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_len = 0;

  always #5 clk = ~clk;

  // Input and output monitors, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && xyz_ch.valid && xyz_ch.ready)
      sb.note_pixel(xyz_ch.x_value, xyz_ch.y_value, xyz_ch.z_value);
  end

  always @(posedge clk) begin
    if (!rst && rgb_ch.valid && rgb_ch.ready)
      sb.check_word('{red: rgb_ch.red_code, green: rgb_ch.green_code,
                      blue: rgb_ch.blue_code});
  end

  // Receiver: random stall before each word, or one long hold when asked.
  initial begin
    int stall;
    rgb_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_len != 0) begin
        rgb_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        rgb_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rgb_ch.ready <= 1'b1;
      do @(posedge clk); while (!rgb_ch.valid);
      @(negedge clk);
    end
  end

  // Offer one pixel after a random gap; returns at the falling edge after acceptance.
  task automatic send_pixel(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      xyz_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    xyz_ch.valid   <= 1'b1;
    xyz_ch.x_value <= x;
    xyz_ch.y_value <= y;
    xyz_ch.z_value <= z;
    do @(posedge clk); while (!xyz_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    xyz_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // One random pixel; mostly in-gamut scale, some tiny, some full range.
  task automatic send_random_pixel();
    int unsigned kind, base;
    logic [IN_W-1:0] x, y, z;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      x = IN_W'($urandom_range(0, 20000));
      y = IN_W'($urandom_range(0, 20000));
      z = IN_W'($urandom_range(0, 20000));
    end else if (kind == 5) begin
      x = IN_W'($urandom_range(0, 120));
      y = IN_W'($urandom_range(0, 120));
      z = IN_W'($urandom_range(0, 120));
    end else if (kind <= 7) begin
      // near-neutral colors: x, y and z follow one shared base, each with small noise
      base = $urandom_range(0, 17000);
      x = IN_W'((base * 95) / 100 + $urandom_range(0, 400));
      y = IN_W'(base + $urandom_range(0, 400));
      z = IN_W'((base * 109) / 100 + $urandom_range(0, 400));
    end else if (kind == 8) begin
      x = IN_W'($urandom());
      y = IN_W'($urandom());
      z = IN_W'($urandom());
    end else begin
      x = ($urandom_range(0, 2) == 0) ? IN_W'($urandom()) : '0;
      y = ($urandom_range(0, 2) == 1) ? IN_W'($urandom()) : '0;
      z = ($urandom_range(0, 2) == 2) ? IN_W'($urandom()) : '0;
    end
    send_pixel(x, y, z);
  endtask

  initial begin
    xyz_ch.valid   = 1'b0;
    xyz_ch.x_value = '0;
    xyz_ch.y_value = '0;
    xyz_ch.z_value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: black, full scale, single primaries, white point, knee and
    // clip boundaries of each channel, negative channels, bit patterns.
    send_pixel(16'd0,     16'd0,     16'd0);
    send_pixel(16'hFFFF,  16'hFFFF,  16'hFFFF);
    send_pixel(16'hFFFF,  16'd0,     16'd0);
    send_pixel(16'd0,     16'hFFFF,  16'd0);
    send_pixel(16'd0,     16'd0,     16'hFFFF);
    send_pixel(16'd15573, 16'd16384, 16'd17842);
    send_pixel(16'd15,    16'd0,     16'd0);
    send_pixel(16'd16,    16'd0,     16'd0);
    send_pixel(16'd0,     16'd26,    16'd0);
    send_pixel(16'd0,     16'd27,    16'd0);
    send_pixel(16'd0,     16'd0,     16'd47);
    send_pixel(16'd0,     16'd0,     16'd48);
    send_pixel(16'd5055,  16'd0,     16'd0);
    send_pixel(16'd5056,  16'd0,     16'd0);
    send_pixel(16'd0,     16'd8733,  16'd0);
    send_pixel(16'd0,     16'd8734,  16'd0);
    send_pixel(16'd0,     16'd0,     16'd15500);
    send_pixel(16'd0,     16'd0,     16'd15501);
    send_pixel(16'd1,     16'd1,     16'd1);
    send_pixel(16'hAAAA,  16'h5555,  16'hAAAA);
    send_pixel(16'h5555,  16'hAAAA,  16'h5555);
    send_pixel(16'd8000,  16'd100,   16'd300);
    drain_results();

    // Random: normal idling, then a stretch with no idling at all.
    for (int i = 0; i < 325; i++) send_random_pixel();
    drain_results();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (int i = 0; i < 325; i++) send_random_pixel();
    drain_results();

    // Back pressure: the receiver holds off long enough for the pipe to fill
    // while the sender keeps offering words.
    rx_quiet = 1'b0;
    hold_len = 80;
    for (int i = 0; i < 325; i++) send_random_pixel();
    tx_quiet = 1'b0;
    drain_results();

    for (int i = 0; i < 325; i++) send_random_pixel();
    drain_results();

    repeat (30) @(negedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
